FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int TAB_W      = 5;
  localparam int IDX_W      = 11;
  localparam int COL_OUT_W  = 7;
  localparam int ROW_OUT_W  = 5;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  localparam logic [ATTR_W-1:0] RST_TEXT_ATTR  = 8'd7;
  localparam logic [TAB_W-1:0]  RST_TAB_SIZE   = 5'd4;
  localparam logic [ATTR_W-1:0] RST_BLANK_ATTR = 8'd7;
  localparam logic [CELL_W-1:0] RST_CELL       = {RST_BLANK_ATTR, 8'h00};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_ATTR  = 2'd0,
    REG_TAB_SIZE   = 2'd1,
    REG_BLANK_ATTR = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_PUT,
    S_TAB_DIV,
    S_TAB_APPLY,
    S_BS_ERASE,
    S_BS_WRAP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCR_COPY,
    S_SCR_DRAIN,
    S_SCR_FILL,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    COL_HOLD, COL_ZERO, COL_INC, COL_DEC, COL_LAST, COL_TAB
  } col_op_t;

  typedef enum logic [1:0] {
    ROW_HOLD, ROW_INC, ROW_DEC, ROW_LAST
  } row_op_t;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_CELL, PTR_PREV, PTR_INC, PTR_DEC, PTR_SRC
  } ptr_op_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_RD_IDX, MEM_RD_PTR, MEM_COPY,
    MEM_WR_CHAR, MEM_WR_BLANK, MEM_WR_FILL, MEM_WR_CLEAR
  } mem_op_t;

  typedef struct packed {
    logic [ATTR_W-1:0] text_attr;
    logic [TAB_W-1:0]  tab_size;
    logic [ATTR_W-1:0] blank_attr;
  } cfg_t;

  typedef struct packed {
    logic    load;
    col_op_t col_op;
    row_op_t row_op;
    ptr_op_t ptr_op;
    mem_op_t mem_op;
    logic    div_init;
    logic    div_step;
    logic    dst_zero;
    logic    sc_set;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic              is_read;
    logic [CHAR_W-1:0] chr;
    logic              col_zero;
    logic              row_zero;
    logic              row_last;
    logic              idx_ok;
    logic              put_wrap;
    logic              tab_wrap;
    logic              div_last;
    logic              scan_hit;
    logic              ptr_last;
    logic              dst_last;
  } status_t;

endpackage

`default_nettype wire

FILE: design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);
  import tcw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (status.dst_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (status.is_read) begin
          state_nxt = status.idx_ok ? S_READ : S_FINISH;
        end else begin
          case (status.chr)
            CH_NL:  state_nxt = status.row_last ? S_SCR_COPY : S_FINISH;
            CH_CR:  state_nxt = S_FINISH;
            CH_TAB: state_nxt = S_TAB_DIV;
            CH_BS: begin
              if (!status.col_zero) state_nxt = S_BS_ERASE;
              else if (status.row_zero) state_nxt = S_FINISH;
              else state_nxt = S_BS_WRAP;
            end
            default: state_nxt = S_PUT;
          endcase
        end
      end
      S_READ:      state_nxt = S_FINISH;
      S_PUT: begin
        state_nxt = (status.put_wrap && status.row_last) ? S_SCR_COPY : S_FINISH;
      end
      S_TAB_DIV: begin
        if (status.div_last) state_nxt = S_TAB_APPLY;
      end
      S_TAB_APPLY: begin
        state_nxt = (status.tab_wrap && status.row_last) ? S_SCR_COPY : S_FINISH;
      end
      S_BS_ERASE:  state_nxt = S_FINISH;
      S_BS_WRAP:   state_nxt = S_SCAN_RD;
      S_SCAN_RD:   state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        state_nxt = (status.scan_hit || status.col_zero) ? S_FINISH : S_SCAN_RD;
      end
      S_SCR_COPY: begin
        if (status.ptr_last) state_nxt = S_SCR_DRAIN;
      end
      S_SCR_DRAIN: state_nxt = S_SCR_FILL;
      S_SCR_FILL: begin
        if (status.dst_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.mem_op = MEM_WR_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        if (!status.is_read) begin
          case (status.chr)
            CH_NL: begin
              cmd.col_op = COL_ZERO;
              if (status.row_last) begin
                cmd.sc_set   = 1'b1;
                cmd.ptr_op   = PTR_SRC;
                cmd.dst_zero = 1'b1;
              end else begin
                cmd.row_op = ROW_INC;
              end
            end
            CH_CR:  cmd.col_op = COL_ZERO;
            CH_TAB: cmd.div_init = 1'b1;
            CH_BS: begin
              cmd.ptr_op = PTR_PREV;
              if (!status.col_zero) begin
                cmd.col_op = COL_DEC;
              end else if (!status.row_zero) begin
                cmd.col_op = COL_LAST;
                cmd.row_op = ROW_DEC;
              end
            end
            default: cmd.ptr_op = PTR_CELL;
          endcase
        end
      end
      S_READ: cmd.mem_op = MEM_RD_IDX;
      S_PUT: begin
        cmd.mem_op = MEM_WR_CHAR;
        if (status.put_wrap) begin
          cmd.col_op = COL_ZERO;
          if (status.row_last) begin
            cmd.sc_set   = 1'b1;
            cmd.ptr_op   = PTR_SRC;
            cmd.dst_zero = 1'b1;
          end else begin
            cmd.row_op = ROW_INC;
          end
        end else begin
          cmd.col_op = COL_INC;
        end
      end
      S_TAB_DIV: cmd.div_step = 1'b1;
      S_TAB_APPLY: begin
        if (status.tab_wrap) begin
          cmd.col_op = COL_ZERO;
          if (status.row_last) begin
            cmd.sc_set   = 1'b1;
            cmd.ptr_op   = PTR_SRC;
            cmd.dst_zero = 1'b1;
          end else begin
            cmd.row_op = ROW_INC;
          end
        end else begin
          cmd.col_op = COL_TAB;
        end
      end
      S_BS_ERASE: cmd.mem_op = MEM_WR_BLANK;
      S_BS_WRAP: begin
        cmd.mem_op = MEM_WR_BLANK;
        cmd.ptr_op = PTR_DEC;
        cmd.col_op = COL_DEC;
      end
      S_SCAN_RD: cmd.mem_op = MEM_RD_PTR;
      S_SCAN_CHK: begin
        if (status.scan_hit) begin
          cmd.col_op = COL_INC;
        end else if (!status.col_zero) begin
          cmd.col_op = COL_DEC;
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_SCR_COPY: begin
        cmd.mem_op = MEM_COPY;
        cmd.ptr_op = PTR_INC;
      end
      S_SCR_DRAIN: cmd.mem_op = MEM_NONE;
      S_SCR_FILL:  cmd.mem_op = MEM_WR_FILL;
      S_FINISH:    cmd.out_load = slot_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/tcw_dpath.sv
// ----------------------------------------------------------------------------
// tcw_dpath
// Cell store, cursor, tab remainder unit, scroll pointers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dpath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tcw_pkg::cfg_t                      cfg,
  input  tcw_pkg::cmd_t                      cmd,
  output tcw_pkg::status_t                   status,
  input  logic                               in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]          in_read_index,
  output logic [tcw_pkg::COL_OUT_W-1:0]      out_col_after,
  output logic [tcw_pkg::ROW_OUT_W-1:0]      out_row_after,
  output logic [tcw_pkg::CHAR_W-1:0]         out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]         out_cell_attr,
  output logic                               out_scrolled
);
  import tcw_pkg::*;

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int NW     = CW + 6;
  localparam int DW     = (CW > 1) ? $clog2(CW) : 1;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
  localparam logic [CW:0]   COLS_C    = (CW + 1)'(COLUMNS);
  localparam logic [NW-1:0] COLS_N    = NW'(COLUMNS);

  logic [CELL_W-1:0] cells_r [NCELLS];

  logic              op_r;
  logic [CHAR_W-1:0] chr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     dst_r;
  logic              pend_r;
  logic              sc_r;
  logic [TAB_W-1:0]  rem_r;
  logic [DW-1:0]     dcnt_r;
  logic [CELL_W-1:0] rd_data_r;

  logic [AW-1:0]     ptr_cell;
  logic [TAB_W-1:0]  tab_eff;
  logic [NW-1:0]     tab_sum;
  logic [TAB_W:0]    trial;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              dst_inc;
  logic              idx_ok;

  assign ptr_cell = AW'(row_r) * COLS_A + AW'(col_r);
  assign tab_eff  = (cfg.tab_size == '0) ? TAB_W'(1) : cfg.tab_size;
  assign tab_sum  = NW'(col_r) + NW'(tab_eff) - NW'(rem_r);
  assign trial    = {rem_r, col_r[dcnt_r]};
  assign idx_ok   = 32'(idx_r) < 32'(NCELLS);

  always_comb begin
    status          = '0;
    status.is_read  = op_r;
    status.chr      = chr_r;
    status.col_zero = (col_r == '0);
    status.row_zero = (row_r == '0);
    status.row_last = (row_r == RW'(ROWS - 1));
    status.idx_ok   = idx_ok;
    status.put_wrap = (({1'b0, col_r} + (CW + 1)'(1)) >= COLS_C);
    status.tab_wrap = (tab_sum >= COLS_N);
    status.div_last = (dcnt_r == '0);
    status.scan_hit = (rd_data_r[CHAR_W-1:0] != '0);
    status.ptr_last = (ptr_r == LAST_CELL);
    status.dst_last = (dst_r == LAST_CELL);
  end

  always_comb begin
    case (cmd.col_op)
      COL_HOLD: col_nxt = col_r;
      COL_ZERO: col_nxt = '0;
      COL_INC:  col_nxt = col_r + CW'(1);
      COL_DEC:  col_nxt = col_r - CW'(1);
      COL_LAST: col_nxt = CW'(COLUMNS - 1);
      COL_TAB:  col_nxt = tab_sum[CW-1:0];
      default:  col_nxt = col_r;
    endcase
  end

  always_comb begin
    case (cmd.row_op)
      ROW_HOLD: row_nxt = row_r;
      ROW_INC:  row_nxt = row_r + RW'(1);
      ROW_DEC:  row_nxt = row_r - RW'(1);
      ROW_LAST: row_nxt = RW'(ROWS - 1);
      default:  row_nxt = row_r;
    endcase
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_HOLD: ptr_nxt = ptr_r;
      PTR_CELL: ptr_nxt = ptr_cell;
      PTR_PREV: ptr_nxt = ptr_cell - AW'(1);
      PTR_INC:  ptr_nxt = ptr_r + AW'(1);
      PTR_DEC:  ptr_nxt = ptr_r - AW'(1);
      PTR_SRC:  ptr_nxt = COLS_A;
      default:  ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r;
    case (cmd.mem_op)
      MEM_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_r);
      end
      MEM_RD_PTR, MEM_COPY: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = {cfg.blank_attr, 8'h00};
    dst_inc = 1'b0;
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = dst_r;
      wr_data = rd_data_r;
      dst_inc = 1'b1;
    end else begin
      case (cmd.mem_op)
        MEM_WR_CHAR: begin
          wr_en   = 1'b1;
          wr_data = {cfg.text_attr, chr_r};
        end
        MEM_WR_BLANK: wr_en = 1'b1;
        MEM_WR_FILL: begin
          wr_en   = 1'b1;
          wr_addr = dst_r;
          dst_inc = 1'b1;
        end
        MEM_WR_CLEAR: begin
          wr_en   = 1'b1;
          wr_addr = dst_r;
          wr_data = RST_CELL;
          dst_inc = 1'b1;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cells_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      dst_r  <= '0;
      pend_r <= 1'b0;
      sc_r   <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= (cmd.mem_op == MEM_COPY);
      if (cmd.dst_zero) begin
        dst_r <= '0;
      end else if (dst_inc) begin
        dst_r <= dst_r + AW'(1);
      end
      if (cmd.load) begin
        sc_r <= 1'b0;
      end else if (cmd.sc_set) begin
        sc_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      op_r  <= in_operation;
      chr_r <= in_char_code;
      idx_r <= in_read_index;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      dcnt_r <= DW'(CW - 1);
    end else if (cmd.div_step) begin
      rem_r  <= (trial >= {1'b0, tab_eff}) ? TAB_W'(trial - {1'b0, tab_eff})
                                           : trial[TAB_W-1:0];
      dcnt_r <= dcnt_r - DW'(1);
    end
    if (cmd.out_load) begin
      out_col_after <= COL_OUT_W'(col_r);
      out_row_after <= ROW_OUT_W'(row_r);
      out_scrolled  <= sc_r;
      if (op_r && idx_ok) begin
        out_cell_char <= rd_data_r[CHAR_W-1:0];
        out_cell_attr <= rd_data_r[CELL_W-1:CHAR_W];
      end else begin
        out_cell_char <= '0;
        out_cell_attr <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console: a grid of character and attribute cells with a cursor.
// Each put interprets one byte (newline, return, tab, backspace or any other
// character) and each read returns one cell; every item gives one result with
// the cursor position after it, and a new item is taken only when the last is
// done. A tab runs the remainder unit, which takes one column bit a cycle. A
// backspace at column 0 of a lower row scans the previous row backwards
// through the single read port of the cell store. A scroll copies the store up
// one row and blanks the bottom row, one cell a cycle. After reset the store
// is cleared, during which in_ready stays low; configuration writes are taken
// at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]         in_read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tcw_pkg::COL_OUT_W-1:0]     out_col_after,
  output logic [tcw_pkg::ROW_OUT_W-1:0]     out_row_after,
  output logic [tcw_pkg::CHAR_W-1:0]        out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]        out_cell_attr,
  output logic                              out_scrolled
);
  import tcw_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_attr  <= RST_TEXT_ATTR;
      cfg_r.tab_size   <= RST_TAB_SIZE;
      cfg_r.blank_attr <= RST_BLANK_ATTR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_ATTR:  cfg_r.text_attr  <= cfg_data[ATTR_W-1:0];
        REG_TAB_SIZE:   cfg_r.tab_size   <= cfg_data[TAB_W-1:0];
        REG_BLANK_ATTR: cfg_r.blank_attr <= cfg_data[ATTR_W-1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .status        (status),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_read_index (in_read_index),
    .out_col_after (out_col_after),
    .out_row_after (out_row_after),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_scrolled  (out_scrolled)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: text console character writer testbench
// Drives put and read beats through the valid/ready input channel and checks
// every result beat against a cycle-free model of the character grid and
// cursor kept in a small scoreboard. Directed beats cover the control codes,
// both ends of the read range and backspace onto the row above. Random beats
// follow under several register settings, with random stalls on both
// channels and one phase without any.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int NCELLS      = COLS * ROWS;
  localparam int PHASES      = 6;
  localparam int BEATS_PER   = 165;
  localparam int SETTLE_CYC  = 16;
  localparam int END_CYC     = NCELLS + 4 * COLS;
  localparam int CYCLE_LIMIT = 10_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [CHAR_W-1:0]    chr;
    logic [ATTR_W-1:0]    attr;
    logic                 scrolled;
  } console_result_t;

  class console_scoreboard;
    logic [CELL_W-1:0] cells [NCELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] text_attr;
    logic [TAB_W-1:0]  tab_size;
    logic [ATTR_W-1:0] blank_attr;
    console_result_t   expected_q [$];
    int unsigned       errors;
    int unsigned       puts;
    int unsigned       reads;
    int unsigned       scrolls;
    int unsigned       row_backs;

    function new();
      foreach (cells[i]) cells[i] = RST_CELL;
      cur_col    = 0;
      cur_row    = 0;
      text_attr  = RST_TEXT_ATTR;
      tab_size   = RST_TAB_SIZE;
      blank_attr = RST_BLANK_ATTR;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TEXT_ATTR:  text_attr  = data[ATTR_W-1:0];
        REG_TAB_SIZE:   tab_size   = data[TAB_W-1:0];
        REG_BLANK_ATTR: blank_attr = data[ATTR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(bit op, logic [CHAR_W-1:0] code, logic [IDX_W-1:0] ridx);
      console_result_t r;
      int              t;
      int              k;
      int              base;
      bit              found;
      r = '0;
      if (op) begin
        reads++;
        if (ridx < NCELLS) begin
          r.chr  = cells[ridx][CHAR_W-1:0];
          r.attr = cells[ridx][CELL_W-1:CHAR_W];
        end
      end else begin
        puts++;
        case (code)
          CH_NL: begin
            cur_col = 0;
            cur_row++;
          end
          CH_CR: cur_col = 0;
          CH_TAB: begin
            t = (tab_size == 0) ? 1 : int'(tab_size);
            cur_col = cur_col + t - (cur_col % t);
            if (cur_col >= COLS) begin
              cur_col = 0;
              cur_row++;
            end
          end
          CH_BS: begin
            if (cur_col > 0) begin
              cur_col--;
              cells[cur_row * COLS + cur_col] = {blank_attr, 8'h00};
            end else if (cur_row > 0) begin
              row_backs++;
              cur_row--;
              base = cur_row * COLS;
              cells[base + COLS - 1] = {blank_attr, 8'h00};
              cur_col = 0;
              found = 1'b0;
              for (k = COLS - 2; k >= 0 && !found; k--) begin
                if (cells[base + k][CHAR_W-1:0] != 0) begin
                  cur_col = k + 1;
                  found = 1'b1;
                end
              end
            end
          end
          default: begin
            cells[cur_row * COLS + cur_col] = {text_attr, code};
            cur_col++;
            if (cur_col >= COLS) begin
              cur_col = 0;
              cur_row++;
            end
          end
        endcase
        if (cur_row >= ROWS) begin
          for (k = 0; k < NCELLS - COLS; k++) cells[k] = cells[k + COLS];
          for (k = NCELLS - COLS; k < NCELLS; k++) cells[k] = {blank_attr, 8'h00};
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
          scrolls++;
        end
      end
      r.col = COL_OUT_W'(cur_col);
      r.row = ROW_OUT_W'(cur_row);
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing outstanding: col %0d row %0d", got.col, got.row);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("col_after", 32'(want.col), 32'(got.col));
      check_field("row_after", 32'(want.row), 32'(got.row));
      check_field("cell_char", 32'(want.chr), 32'(got.chr));
      check_field("cell_attr", 32'(want.attr), 32'(got.attr));
      check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = 1'b0;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic [IDX_W-1:0]      in_read_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COL_OUT_W-1:0]  out_col_after;
  logic [ROW_OUT_W-1:0]  out_row_after;
  logic [CHAR_W-1:0]     out_cell_char;
  logic [ATTR_W-1:0]     out_cell_attr;
  logic                  out_scrolled;

  bit                    calm = 1'b0;
  console_scoreboard     sb;

  text_console_char_writer #(
    .COLUMNS (COLS),
    .ROWS    (ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_read_index (in_read_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_col_after (out_col_after),
    .out_row_after (out_row_after),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_scrolled  (out_scrolled)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(CYCLE_LIMIT * 10);
    $display("simulation limit reached with %0d results outstanding", sb.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input bit op, input logic [CHAR_W-1:0] code,
                           input logic [IDX_W-1:0] ridx);
    if (!calm) begin
      while ($urandom_range(0, 99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_char_code  <= code;
    in_read_index <= ridx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, code, ridx);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // result side: check each accepted beat, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result({out_col_after, out_row_after, out_cell_char, out_cell_attr,
                         out_scrolled});
      out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  initial begin
    int               p;
    int               n;
    int               pick;
    bit               op;
    logic [CHAR_W-1:0] code;
    logic [IDX_W-1:0] ridx;
    cfg_t             plan [PHASES];

    sb = new();
    plan[0] = {RST_TEXT_ATTR, RST_TAB_SIZE, RST_BLANK_ATTR};
    plan[1] = {8'hFF, 5'd16, 8'h00};
    plan[2] = {8'h00, 5'd1, 8'hFF};
    plan[3] = {8'hA5, 5'd0, 8'h5A};
    plan[4] = {8'h3C, 5'd31, 8'hC3};
    plan[5].text_attr  = ATTR_W'($urandom_range(0, 255));
    plan[5].tab_size   = TAB_W'($urandom_range(1, 16));
    plan[5].blank_attr = ATTR_W'($urandom_range(0, 255));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(1'b0, CH_BS, '0);
    send_item(1'b1, 8'h00, 11'd0);
    send_item(1'b1, 8'hFF, IDX_W'(NCELLS - 1));
    send_item(1'b1, 8'h00, 11'h7FF);
    send_item(1'b1, 8'h00, IDX_W'(NCELLS));
    send_item(1'b0, 8'h41, '0);
    send_item(1'b0, 8'hFF, '0);
    send_item(1'b0, 8'h00, '0);
    send_item(1'b0, 8'h80, '0);
    send_item(1'b0, CH_BS, '0);
    send_item(1'b0, CH_TAB, '0);
    send_item(1'b0, CH_TAB, '0);
    send_item(1'b0, CH_CR, '0);
    send_item(1'b0, 8'h7E, '0);
    send_item(1'b0, CH_NL, '0);
    send_item(1'b0, CH_BS, '0);
    send_item(1'b1, 8'h00, 11'd1);
    send_item(1'b1, 8'h00, 11'd2);
    send_item(1'b1, 8'h00, 11'd3);
    send_item(1'b0, CH_NL, '0);
    send_item(1'b0, CH_NL, '0);
    send_item(1'b0, CH_BS, '0);
    send_item(1'b1, 8'h00, IDX_W'(COLS - 1));

    for (p = 0; p < PHASES; p++) begin
      drain(SETTLE_CYC);
      if (p == 3)
        write_reg(REG_SPARE, 8'hFF);
      write_reg(REG_TEXT_ATTR, plan[p].text_attr);
      write_reg(REG_TAB_SIZE, {3'b000, plan[p].tab_size});
      write_reg(REG_BLANK_ATTR, plan[p].blank_attr);
      cfg_we <= 1'b0;
      @(posedge clk);
      calm = (p == 2);

      for (n = 0; n < BEATS_PER; n++) begin
        pick = int'($urandom_range(0, 99));
        op   = 1'b0;
        code = CHAR_W'($urandom_range(0, 255));
        ridx = IDX_W'($urandom_range(0, 2047));
        if (pick < 28) begin
          op = 1'b1;
          // bias reads towards the row under the cursor
          if ($urandom_range(0, 9) >= 3)
            ridx = IDX_W'(sb.cur_row * COLS + int'($urandom_range(0, COLS - 1)));
          else if ($urandom_range(0, 2) != 0)
            ridx = IDX_W'($urandom_range(0, NCELLS - 1));
        end else if (pick < 36) begin
          code = CH_NL;
        end else if (pick < 40) begin
          code = CH_CR;
        end else if (pick < 47) begin
          code = CH_TAB;
        end else if (pick < 57) begin
          code = CH_BS;
        end
        send_item(op, code, ridx);
      end
    end

    calm = 1'b0;
    drain(END_CYC);
    $display("covered %0d puts and %0d reads over %0d register settings",
             sb.puts, sb.reads, PHASES);
    $display("grid scrolled %0d times, backspace stepped onto the row above %0d times",
             sb.scrolls, sb.row_backs);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_dpath.sv
design/text_console_char_writer.sv
tb/tb_top.sv
